>>> rtl/isolated_pixel_despeckle_macros.svh
// ----------------------------------------------------------------------------
// isolated_pixel_despeckle_macros.svh
// assertion shorthands shared by the despeckle rtl
// ----------------------------------------------------------------------------
`ifndef ISOLATED_PIXEL_DESPECKLE_MACROS_SVH
`define ISOLATED_PIXEL_DESPECKLE_MACROS_SVH

// condition must hold at every edge out of reset
`define IPD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define IPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// shared constants, register indexes, fsm states and control structs
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W   = 10;
  localparam int LEVEL_W    = 4;
  localparam int THR_W      = 4;
  localparam int GLYPH_W    = 7;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 4'd9;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_SELF,
    ST_FETCH_RIGHT,
    ST_EMIT_UPPER,
    ST_EMIT_LEFT,
    ST_EMIT_FINAL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture_in;   // latch the accepted request
    logic fetch_self;   // take center and upper level, point read at right
    logic fetch_right;  // take right level, store raw pixel
    logic emit_upper;   // finish pixel one row above
    logic emit_left;    // finish last-row pixel to the left
    logic emit_final;   // finish last pixel of the image
    logic advance;      // step raster position
    logic restart;      // back to row 0, column 0
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_zero;
    logic last_row;
    logic col_zero;
    logic last_col;
    logic slot_free;
  } status_t;

endpackage

>>> rtl/ipd_ram.sv
// ----------------------------------------------------------------------------
// ipd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ipd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ipd_ctrl.sv
// ----------------------------------------------------------------------------
// ipd_ctrl
// sequencer: fetches neighbors of one request, then emits up to three results
// ----------------------------------------------------------------------------
`include "isolated_pixel_despeckle_macros.svh"

module ipd_ctrl import ipd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FETCH_SELF;
      end
      ST_FETCH_SELF: begin
        state_nxt = ST_FETCH_RIGHT;
      end
      ST_FETCH_RIGHT: begin
        state_nxt = status.row_zero ? ST_IDLE : ST_EMIT_UPPER;
      end
      ST_EMIT_UPPER: begin
        if (status.slot_free) begin
          state_nxt = (status.last_row && !status.col_zero) ? ST_EMIT_LEFT : ST_IDLE;
        end
      end
      ST_EMIT_LEFT: begin
        if (status.slot_free) begin
          state_nxt = status.last_col ? ST_EMIT_FINAL : ST_IDLE;
        end
      end
      ST_EMIT_FINAL: begin
        if (status.slot_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.capture_in = in_valid;
      end
      ST_FETCH_SELF: begin
        cmd.fetch_self = 1'b1;
      end
      ST_FETCH_RIGHT: begin
        cmd.fetch_right = 1'b1;
        cmd.advance     = status.row_zero;
      end
      ST_EMIT_UPPER: begin
        cmd.emit_upper = status.slot_free;
        cmd.advance    = status.slot_free && !(status.last_row && !status.col_zero);
      end
      ST_EMIT_LEFT: begin
        cmd.emit_left = status.slot_free;
        cmd.advance   = status.slot_free && !status.last_col;
      end
      ST_EMIT_FINAL: begin
        cmd.emit_final = status.slot_free;
        cmd.restart    = status.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // checks
  `IPD_ASSERT_ALWAYS(a_one_emit, $onehot0({cmd.emit_upper, cmd.emit_left, cmd.emit_final}), "more than one result loaded in a cycle")
  `IPD_ASSERT_IMP(a_final_corner, cmd.emit_final, status.last_row && status.last_col, "final result away from the image corner")
  `IPD_ASSERT_NEXT(a_back_to_idle, cmd.advance || cmd.restart, state_r == ST_IDLE, "position moved without returning to idle")

endmodule

>>> rtl/ipd_datapath.sv
// ----------------------------------------------------------------------------
// ipd_datapath
// config registers, raster position, row buffers, correction and output register
// ----------------------------------------------------------------------------
`include "isolated_pixel_despeckle_macros.svh"

module ipd_datapath import ipd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [LEVEL_W-1:0]    in_pixel_level,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [HEIGHT_W-1:0]   out_row,
  output logic [COL_W-1:0]      out_col,
  output logic [LEVEL_W-1:0]    out_level,
  output logic [GLYPH_W-1:0]    out_glyph,
  output logic                  out_image_done,
  input  cmd_t                  cmd,
  output status_t               status
);

  // glyph ramp, codes above nine read as the densest glyph
  localparam logic [GLYPH_W-1:0] GLYPH_RAMP [16] = '{
    7'd32, 7'd46, 7'd39, 7'd58, 7'd126, 7'd42, 7'd61, 7'd38,
    7'd37, 7'd35, 7'd35, 7'd35, 7'd35,  7'd35, 7'd35, 7'd35
  };

  // replace the center by the neighbor average when it beats every present neighbor
  function automatic logic [LEVEL_W-1:0] fix_level(
    input logic [LEVEL_W-1:0]            self_lv,
    input logic [THR_W-1:0]              thr,
    input logic [3:0]                    pres,
    input logic [3:0][LEVEL_W-1:0]       nbv
  );
    logic [5:0]         sum;
    logic [2:0]         cnt;
    logic               all_hi;
    logic [9:0]         prod;
    logic [LEVEL_W-1:0] res;
    sum    = '0;
    cnt    = '0;
    all_hi = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (pres[i]) begin
        sum = sum + {2'b00, nbv[i]};
        cnt = cnt + 3'd1;
        if ({1'b0, self_lv} <= ({1'b0, nbv[i]} + {1'b0, thr})) all_hi = 1'b0;
      end
    end
    // divide by three as multiply by 11/32, exact for sums up to 27
    prod = {4'd0, sum} * 10'd11;
    unique case (cnt)
      3'd2:    res = sum[4:1];
      3'd3:    res = prod[8:5];
      3'd4:    res = sum[5:2];
      default: res = self_lv;
    endcase
    if (!all_hi) res = self_lv;
    return res;
  endfunction

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [THR_W-1:0]    thresh_r;
  logic [HEIGHT_W-1:0] row_r;
  logic [COL_W-1:0]    col_r;
  logic [LEVEL_W-1:0]  left_cor_r;
  logic [LEVEL_W-1:0]  p_r;
  logic [LEVEL_W-1:0]  p_last_r;
  logic [LEVEL_W-1:0]  self_r;
  logic [LEVEL_W-1:0]  up_r;
  logic [LEVEL_W-1:0]  right_r;
  logic [LEVEL_W-1:0]  upper_cur_r;
  logic [LEVEL_W-1:0]  upper_last_r;
  logic                out_valid_r;
  logic [HEIGHT_W-1:0] out_row_r;
  logic [COL_W-1:0]    out_col_r;
  logic [LEVEL_W-1:0]  out_level_r;
  logic [GLYPH_W-1:0]  out_glyph_r;
  logic                out_done_r;

  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic                last_col;
  logic                last_row;
  logic                geo_write;
  logic                any_emit;
  logic [LEVEL_W-1:0]  p_clamped;
  logic [LEVEL_W-1:0]  raw_rdata;
  logic [LEVEL_W-1:0]  cor_rdata;
  logic [COL_W-1:0]    raw_raddr;

  logic [LEVEL_W-1:0]        op_self;
  logic [3:0]                op_pres;
  logic [3:0][LEVEL_W-1:0]   op_nbv;
  logic [LEVEL_W-1:0]        fixed;

  // effective geometry
  always_comb begin
    if (width_r < WIDTH_W'(2)) begin
      width_eff = WIDTH_W'(2);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = width_r;
    end
    height_eff = (height_r < HEIGHT_W'(2)) ? HEIGHT_W'(2) : height_r;
  end

  assign last_col  = ({1'b0, col_r} == (width_eff - WIDTH_W'(1)));
  assign last_row  = (row_r == (height_eff - HEIGHT_W'(1)));
  assign any_emit  = cmd.emit_upper || cmd.emit_left || cmd.emit_final;
  assign geo_write = cfg_we && ((cfg_idx_t'(cfg_index) == CFG_WIDTH) ||
                                (cfg_idx_t'(cfg_index) == CFG_HEIGHT));
  assign p_clamped = (in_pixel_level > MAX_LEVEL) ? MAX_LEVEL : in_pixel_level;

  assign status.row_zero  = (row_r == '0);
  assign status.last_row  = last_row;
  assign status.col_zero  = (col_r == '0);
  assign status.last_col  = last_col;
  assign status.slot_free = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(30);
      height_r <= HEIGHT_W'(20);
      thresh_r <= THR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:     width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_HEIGHT:    height_r <= cfg_wdata[HEIGHT_W-1:0];
        CFG_THRESHOLD: thresh_r <= cfg_wdata[THR_W-1:0];
        default:       thresh_r <= thresh_r;
      endcase
    end
  end

  // raster position and corrected left neighbor in the last row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      left_cor_r <= '0;
    end else if (geo_write || cmd.restart) begin
      row_r      <= '0;
      col_r      <= '0;
      left_cor_r <= '0;
    end else begin
      if (cmd.emit_left) left_cor_r <= fixed;
      if (cmd.advance) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + HEIGHT_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (cmd.capture_in) p_r <= p_clamped;
    if (cmd.fetch_self) begin
      self_r <= raw_rdata;
      up_r   <= cor_rdata;
    end
    if (cmd.fetch_right) right_r <= raw_rdata;
    if (cmd.emit_upper) upper_cur_r <= fixed;
    if (cmd.advance) begin
      upper_last_r <= cmd.emit_upper ? fixed : upper_cur_r;
      p_last_r     <= p_r;
    end
  end

  // row buffers: raw levels of the pending row, corrected levels of the row above
  assign raw_raddr = cmd.fetch_self ? (col_r + COL_W'(1)) : col_r;

  ipd_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_WIDTH)) u_raw_ram (
    .clk   (clk),
    .we    (cmd.fetch_right),
    .waddr (col_r),
    .wdata (p_r),
    .raddr (raw_raddr),
    .rdata (raw_rdata)
  );

  ipd_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_WIDTH)) u_cor_ram (
    .clk   (clk),
    .we    (cmd.emit_upper),
    .waddr (col_r),
    .wdata (fixed),
    .raddr (col_r),
    .rdata (cor_rdata)
  );

  // operand select, neighbor order left, right, up, down
  always_comb begin
    if (cmd.emit_left) begin
      op_self = p_last_r;
      op_pres = {1'b0, 1'b1, 1'b1, (col_r[COL_W-1:1] != '0)};
      op_nbv  = {{LEVEL_W{1'b0}}, upper_last_r, p_r, left_cor_r};
    end else if (cmd.emit_final) begin
      op_self = p_r;
      op_pres = {1'b0, 1'b1, 1'b0, 1'b1};
      op_nbv  = {{LEVEL_W{1'b0}}, upper_cur_r, {LEVEL_W{1'b0}}, left_cor_r};
    end else begin
      op_self = self_r;
      op_pres = {1'b1, (row_r > HEIGHT_W'(1)), !last_col, (col_r != '0)};
      op_nbv  = {p_r, up_r, right_r, upper_last_r};
    end
  end

  assign fixed = fix_level(op_self, thresh_r, op_pres, op_nbv);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (any_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (any_emit) begin
      out_row_r   <= cmd.emit_upper ? (row_r - HEIGHT_W'(1)) : row_r;
      out_col_r   <= cmd.emit_left ? (col_r - COL_W'(1)) : col_r;
      out_level_r <= fixed;
      out_glyph_r <= GLYPH_RAMP[fixed];
      out_done_r  <= cmd.emit_final;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_level      = out_level_r;
  assign out_glyph      = out_glyph_r;
  assign out_image_done = out_done_r;

  // checks
  `IPD_ASSERT_ALWAYS(a_col_range, {1'b0, col_r} < width_eff, "column beyond image width")
  `IPD_ASSERT_ALWAYS(a_row_range, row_r < height_eff, "row beyond image height")
  `IPD_ASSERT_IMP(a_upper_row, cmd.emit_upper, row_r != '0, "upper result requested on the first row")

endmodule

>>> rtl/isolated_pixel_despeckle.sv
// ----------------------------------------------------------------------------
// isolated_pixel_despeckle
// four-neighbor outlier smoothing of a raster stream of gray levels 0..9
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one request per accepted in_pixel_level; levels
// above 9 are clamped. A pixel that beats every existing neighbor by more than
// the threshold becomes the truncated average of those neighbors; left and
// upper neighbors are already corrected, right and lower ones are raw. A pixel
// is emitted when the pixel below it arrives; last-row pixels follow their
// right neighbor and the image corner comes out with the last input, flagged by
// out_image_done. Each request fetches its own and upper levels, then its right
// neighbor, then emits the pixel above, the last-row pixel to its left and the
// image corner where they are due, and waits while out_ready holds a result
// back: two reads of the pending-row buffer share its single read port, and the
// output register takes one result per cycle when its slot is free. The
// next request is taken while the last result still waits. Writing the width
// or height restarts the image at row 0, column 0. Row buffers need no clearing
// after reset.
module isolated_pixel_despeckle import ipd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LEVEL_W-1:0]    in_pixel_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [HEIGHT_W-1:0]   out_row,
  output logic [COL_W-1:0]      out_col,
  output logic [LEVEL_W-1:0]    out_level,
  output logic [GLYPH_W-1:0]    out_glyph,
  output logic                  out_image_done
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  ipd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and arithmetic
  ipd_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_pixel_level (in_pixel_level),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_level      (out_level),
    .out_glyph      (out_glyph),
    .out_image_done (out_image_done),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the isolated pixel despeckle block
// ----------------------------------------------------------------------------
// Raster pixels are pushed through the input request channel while a local
// predictor keeps its own copy of the row buffers and raster position. Every
// accepted request queues the corrected pixels it releases. Each result taken
// off the output channel is compared field by field against the oldest queued
// pixel. Both channels idle at random. One phase holds the output off long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ipd_pkg::*;

  localparam int ITEM_TARGET = 310;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 100;
  localparam int TIMEOUT_NS  = 3_000_000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [HEIGHT_W-1:0] row;
    logic [COL_W-1:0]    col;
    logic [LEVEL_W-1:0]  level;
    logic [GLYPH_W-1:0]  glyph;
    logic                done;
  } corrected_px_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [LEVEL_W-1:0]    in_pixel_level = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [HEIGHT_W-1:0]   out_row;
  logic [COL_W-1:0]      out_col;
  logic [LEVEL_W-1:0]    out_level;
  logic [GLYPH_W-1:0]    out_glyph;
  logic                  out_image_done;

  // predictor state
  logic [WIDTH_W-1:0]  width_reg  = 7'd30;
  logic [HEIGHT_W-1:0] height_reg = 10'd20;
  logic [THR_W-1:0]    thr_reg    = 4'd1;
  logic [LEVEL_W-1:0]  above_corr [MAX_WIDTH];
  logic [LEVEL_W-1:0]  raw_row    [MAX_WIDTH];
  logic [LEVEL_W-1:0]  left_corr  = '0;
  int                  pos_row    = 0;
  int                  pos_col    = 0;
  string               glyph_ramp = " .':~*=&%#";

  corrected_px_t corrected_due [$];
  corrected_px_t due_px;
  int            errors        = 0;
  int            pixels_sent   = 0;
  bit            steady        = 1'b0;
  int            hold_requests = 0;
  int            holds_done    = 0;
  int            stall_left    = 0;
  int            ready_gap     = 0;

  isolated_pixel_despeckle DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_level (in_pixel_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_level      (out_level),
    .out_glyph      (out_glyph),
    .out_image_done (out_image_done)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      above_corr[i] = '0;
      raw_row[i]    = '0;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly dark background with bright spikes, full 4-bit range
  function automatic logic [LEVEL_W-1:0] random_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return LEVEL_W'($urandom_range(0, 2));
    if (r < 80) return LEVEL_W'($urandom_range(0, 15));
    return LEVEL_W'($urandom_range(6, 15));
  endfunction

  // small thresholds most of the time so pixels do get replaced
  function automatic int pick_threshold();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 3);
    return $urandom_range(4, 15);
  endfunction

  function automatic int eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int eff_height();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  // pixel becomes the neighbor average when it beats every present neighbor
  function automatic logic [LEVEL_W-1:0] smooth_level(
      input int self_lv,
      input bit has_l, input int l_lv, input bit has_r, input int r_lv,
      input bit has_u, input int u_lv, input bit has_d, input int d_lv);
    int nb [4];
    bit has [4];
    int sum;
    int cnt;
    int thr;
    bit beats_all;
    nb        = '{l_lv, r_lv, u_lv, d_lv};
    has       = '{has_l, has_r, has_u, has_d};
    sum       = 0;
    cnt       = 0;
    thr       = thr_reg;
    beats_all = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (has[k]) begin
        sum += nb[k];
        cnt++;
        if (self_lv - nb[k] <= thr) beats_all = 1'b0;
      end
    end
    if (beats_all && cnt > 0) return LEVEL_W'(sum / cnt);
    return LEVEL_W'(self_lv);
  endfunction

  function automatic void queue_corrected(input int row, input int col,
                                          input logic [LEVEL_W-1:0] v, input bit done);
    corrected_px_t px;
    px.row   = HEIGHT_W'(row);
    px.col   = COL_W'(col);
    px.level = v;
    px.glyph = GLYPH_W'(glyph_ramp[v]);
    px.done  = done;
    corrected_due.push_back(px);
  endfunction

  function automatic void restart_image();
    pos_row   = 0;
    pos_col   = 0;
    left_corr = '0;
  endfunction

  // one accepted pixel: finish what it completes and advance the scan
  function automatic void despeckle_step(input logic [LEVEL_W-1:0] lvl);
    int w;
    int h;
    int r;
    int c;
    int p;
    logic [LEVEL_W-1:0] v;
    w = eff_width();
    h = eff_height();
    r = pos_row;
    c = pos_col;
    p = (lvl > MAX_LEVEL) ? MAX_LEVEL : lvl;
    if (c >= w) c = w - 1;

    // pixel above is complete once its lower neighbor arrives
    if (r >= 1) begin
      v = smooth_level(raw_row[c],
                       c > 0, (c > 0) ? above_corr[c - 1] : 0,
                       c + 1 < w, (c + 1 < w) ? raw_row[c + 1] : 0,
                       r >= 2, (r >= 2) ? above_corr[c] : 0,
                       1'b1, p);
      above_corr[c] = v;
      queue_corrected(r - 1, c, v, 1'b0);
    end
    raw_row[c] = LEVEL_W'(p);

    // last row streams out behind its right neighbor
    if (r == h - 1) begin
      if (c >= 1) begin
        v = smooth_level(raw_row[c - 1], c >= 2, left_corr, 1'b1, p,
                         1'b1, above_corr[c - 1], 1'b0, 0);
        left_corr = v;
        queue_corrected(r, c - 1, v, 1'b0);
      end
      if (c == w - 1) begin
        v = smooth_level(p, c >= 1, left_corr, 1'b0, 0, 1'b1, above_corr[c], 1'b0, 0);
        queue_corrected(r, c, v, 1'b1);
        restart_image();
        return;
      end
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    pos_row = r;
    pos_col = c;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("%s mismatch: got %0d expected %0d", name, got, want));
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (corrected_due.size() == 0) begin
        report_error($sformatf("result row %0d col %0d with no pixel pending",
                               out_row, out_col));
      end else begin
        due_px = corrected_due.pop_front();
        check_field("out_row", out_row, due_px.row);
        check_field("out_col", out_col, due_px.col);
        check_field("out_level", out_level, due_px.level);
        check_field("out_glyph", out_glyph, due_px.glyph);
        check_field("out_image_done", out_image_done, due_px.done);
      end
    end
  end

  // receiver: random gaps, plus long hold-offs on request
  always @(negedge clk) begin
    if (holds_done != hold_requests) begin
      out_ready  <= 1'b0;
      stall_left <= HOLD_CYCLES - 1;
      holds_done <= holds_done + 1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (ready_gap > 0) begin
      out_ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else begin
      out_ready <= rst_n;
      ready_gap <= steady ? 0 : gap_len();
    end
  end

  // offer one pixel request and hold it until taken
  task automatic send_pixel(input logic [LEVEL_W-1:0] lvl);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_pixel_level <= lvl;
    do @(posedge clk); while (!in_ready);
    despeckle_step(lvl);
    pixels_sent++;
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid       <= 1'b0;
      in_pixel_level <= LEVEL_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_random_pixels(input int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(random_level());
      if (!steady) pause_input(gap_len());
    end
  endtask

  task automatic send_levels(input int lv [$]);
    foreach (lv[i]) send_pixel(LEVEL_W'(lv[i]));
  endtask

  // stop sending, drain every pending pixel, let a silent request finish
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (corrected_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, unused upper data bits randomized
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    int fw;
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] wdata;
    case (idx)
      CFG_WIDTH:     fw = WIDTH_W;
      CFG_THRESHOLD: fw = THR_W;
      default:       fw = CFG_DATA_W;
    endcase
    mask  = CFG_DATA_W'((1 << fw) - 1);
    wdata = (CFG_DATA_W'(value) & mask) | (CFG_DATA_W'($urandom) & ~mask);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    case (idx)
      CFG_WIDTH: begin
        width_reg = wdata[WIDTH_W-1:0];
        restart_image();
      end
      CFG_HEIGHT: begin
        height_reg = wdata[HEIGHT_W-1:0];
        restart_image();
      end
      CFG_THRESHOLD: thr_reg = wdata[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // register values out of reset: 30 wide, threshold 1
  task automatic test_reset_defaults();
    send_random_pixels(33);
  endtask

  // 2x2 and 3x3 images: clamping, threshold edges, restart, spare index
  task automatic test_corner_spikes();
    settle_block();
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 1);
    write_reg(CFG_THRESHOLD, 0);
    send_levels('{15, 0, 0, 0});
    send_levels('{0, 0, 0, 12});
    // threshold change inside an image keeps the scan position
    settle_block();
    write_reg(CFG_THRESHOLD, 9);
    send_levels('{9, 0});
    settle_block();
    write_reg(CFG_THRESHOLD, 8);
    send_levels('{0, 0});
    // threshold above 9, spare index, geometry rewrite mid image
    settle_block();
    write_reg(CFG_THRESHOLD, 15);
    write_reg(CFG_SPARE, $urandom_range(0, 1023));
    send_levels('{9, 0});
    settle_block();
    write_reg(CFG_HEIGHT, 2);
    send_levels('{9, 0, 0, 9});
    // four-neighbor average at the center
    settle_block();
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 3);
    write_reg(CFG_THRESHOLD, 0);
    send_levels('{1, 2, 3, 4, 9, 5, 6, 7, 0});
  endtask

  // long output hold-off while the input keeps offering requests
  task automatic test_output_stall();
    settle_block();
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_HEIGHT, 3);
    write_reg(CFG_THRESHOLD, 1);
    steady = 1'b1;
    hold_requests++;
    send_random_pixels(24);
    settle_block();
    steady = 1'b0;
  endtask

  // tallest height, narrowest width, image left unfinished
  task automatic test_tall_image();
    settle_block();
    write_reg(CFG_HEIGHT, 1023);
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_THRESHOLD, 2);
    send_random_pixels(24);
  endtask

  // width above the buffer size clipped to the full row
  task automatic test_wide_image();
    settle_block();
    write_reg(CFG_WIDTH, 127);
    write_reg(CFG_HEIGHT, 0);
    write_reg(CFG_THRESHOLD, $urandom_range(0, 2));
    send_random_pixels(MAX_WIDTH * 2);
  endtask

  // small random geometries, some images abandoned or retuned midway
  task automatic test_random_images();
    int w_val;
    int h_val;
    int total;
    int split;
    while (pixels_sent < ITEM_TARGET) begin
      settle_block();
      w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
      write_reg(CFG_HEIGHT, h_val);
      write_reg(CFG_WIDTH, w_val);
      write_reg(CFG_THRESHOLD, pick_threshold());
      steady = ($urandom_range(0, 3) == 0);
      total  = eff_width() * eff_height();
      if ($urandom_range(0, 5) == 0) total = $urandom_range(1, total - 1);
      split = (total > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : total;
      send_random_pixels(split);
      if (split < total) begin
        settle_block();
        write_reg(CFG_THRESHOLD, pick_threshold());
        send_random_pixels(total - split);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_corner_spikes();
    test_output_stall();
    test_tall_image();
    test_wide_image();
    test_random_images();
    settle_block();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // overall time limit
  initial begin
    #TIMEOUT_NS;
    $display("FAILURE");
    $finish;
  end

endmodule
